// File: rtl/assert_macros.svh
// Assertion macros shared by the tag cache RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a boolean condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/ltc_pkg.sv
// Shared widths, codes and sequencer states of the tile tag cache.
// No dependencies; used by the interfaces and the top level.
package ltc_pkg;

    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 10;
    localparam int LEVEL_W  = 6;
    localparam int TILE_W   = 32;
    localparam int KEY_W    = CHAN_W + LEVEL_W + TILE_W;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int MAXT_W   = 7;
    localparam int EVN_W    = 6;

    localparam logic [MAXT_W-1:0] MAXT_RST     = 7'd64;
    localparam logic [EVN_W-1:0]  EVICT_CAP    = 6'd63;
    localparam logic [EVN_W-1:0]  EVICT_CAP_M1 = 6'd62;

    // Request codes; any code other than insert and clear is a lookup
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_TOUCH,
        S_EVCHK,
        S_EVICT,
        S_EVSCAN,
        S_PLACE,
        S_INCR,
        S_INS,
        S_EMIT,
        S_CLEAR
    } state_t;

endpackage

// File: rtl/ltc_if.sv
// Handshake channels of the tile tag cache: request, result and configuration.
// Depends on ltc_pkg for the field widths.
interface ltc_req_if;
    logic                         valid;
    logic                         ready;
    logic [ltc_pkg::FUNC_W-1:0]   func;
    logic [ltc_pkg::CHAN_W-1:0]   channel;
    logic [ltc_pkg::LEVEL_W-1:0]  level;
    logic [ltc_pkg::TILE_W-1:0]   tile_index;

    modport source (output valid, output func, output channel, output level,
                    output tile_index, input ready);
    modport sink   (input valid, input func, input channel, input level,
                    input tile_index, output ready);
endinterface

interface ltc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ltc_pkg::STATUS_W-1:0]  status;
    logic [ltc_pkg::SLOT_W-1:0]    slot;
    logic [ltc_pkg::CHAN_W-1:0]    evict_channel;
    logic [ltc_pkg::LEVEL_W-1:0]   evict_level;
    logic [ltc_pkg::TILE_W-1:0]    evict_tile;
    logic                          last;

    modport source (output valid, output status, output slot, output evict_channel,
                    output evict_level, output evict_tile, output last, input ready);
    modport sink   (input valid, input status, input slot, input evict_channel,
                    input evict_level, input evict_tile, input last, output ready);
endinterface

interface ltc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ltc_pkg::MAXT_W-1:0]  max_tiles;

    modport source (output valid, output max_tiles, input ready);
    modport sink   (input valid, input max_tiles, output ready);
endinterface

// File: rtl/lru_tile_tag_cache.sv
// A request runs as sweeps over the key/rank RAM: a lookup scans, and on a hit a second
// sweep ages the younger entries; an insert of a new key scans, emits a victim word for
// each least recent entry that it evicts, rescanning before each further victim, then
// ages every entry and writes the key. A clear gives its single result word without a sweep.
// Request ready only when idle: a new request is taken only after the last one has loaded
// its final result word. rst_n (async, low) empties the store, sets max_tiles to 64.
`include "assert_macros.svh"

module lru_tile_tag_cache #(
    parameter int ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    ltc_req_if.sink      req,
    ltc_rsp_if.source    rsp,
    ltc_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int AW  = $clog2(ENTRIES);        // entry index
    localparam int OW  = $clog2(ENTRIES + 1);    // occupancy, 0..ENTRIES
    localparam int CW  = OW;                     // sweep counter, 0..ENTRIES
    localparam int RW  = AW;                     // recency rank, 0..ENTRIES-1
    localparam int KW  = ltc_pkg::KEY_W;
    localparam int DW  = KW + RW;                // RAM word: {rank, key}
    localparam int MW  = ltc_pkg::MAXT_W;
    localparam int LW  = (OW > MW) ? OW : MW;    // limit compare width
    localparam int SW  = ltc_pkg::SLOT_W;
    localparam int EW  = ltc_pkg::EVN_W;
    localparam int TW  = ltc_pkg::TILE_W;
    localparam int LVW = ltc_pkg::LEVEL_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ltc_pkg::state_t state_reg, state_next;

    logic [ltc_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [KW-1:0]              key_reg, key_next;
    logic [MW-1:0]              max_tiles_reg, max_tiles_next;
    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [OW-1:0]              occ_reg, occ_next;

    // Sweep counter and the one-deep read pipeline behind the RAM
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [AW-1:0]              rd_idx_reg, rd_idx_next;

    // What the sweeps find
    logic                       hit_found_reg, hit_found_next;
    logic [AW-1:0]              hit_idx_reg, hit_idx_next;
    logic [RW-1:0]              hit_rank_reg, hit_rank_next;
    logic                       old_found_reg, old_found_next;
    logic [AW-1:0]              old_idx_reg, old_idx_next;
    logic [KW-1:0]              old_key_reg, old_key_next;
    logic                       free_found_reg, free_found_next;
    logic [AW-1:0]              free_idx_reg, free_idx_next;
    logic [EW-1:0]              evn_reg, evn_next;
    logic [ltc_pkg::STATUS_W-1:0] st_reg, st_next;

    // Result register
    logic                         rsp_vld_reg, rsp_vld_next;
    logic [ltc_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [SW-1:0]                rsp_slot_reg;
    logic [KW-1:0]                rsp_key_reg;
    logic                         rsp_last_reg;

    // ------------------------------------------------------------------
    // RAM and read-side decode
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    ltc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [KW-1:0] rd_key;
    logic [RW-1:0] rd_rank;
    logic [RW-1:0] rd_rank_inc;
    logic          rd_valid;
    logic [OW-1:0] occ_m1;
    logic          rd_oldest;

    assign rd_key      = ram_rdata[KW-1:0];
    assign rd_rank     = ram_rdata[DW-1:KW];
    assign rd_rank_inc = rd_rank + RW'(1);
    assign rd_valid    = valid_reg[rd_idx_reg];
    assign occ_m1      = occ_reg - OW'(1);
    // The valid ranks are always 0..occ-1, so the least recent entry is the
    // one whose rank equals occ-1.
    assign rd_oldest   = rd_valid && (OW'(rd_rank) == occ_m1);

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    logic issue;        // counter still has an address to read
    logic sweep_done;   // last read data consumed
    logic in_sweep;
    logic out_free;     // result register can take a word this cycle
    logic accept;
    logic [LW-1:0] lim;
    logic need_evict;
    logic more_evict;

    assign issue      = (cnt_reg < CW'(ENTRIES));
    assign sweep_done = !issue && !rd_vld_reg;
    assign in_sweep   = (state_reg == ltc_pkg::S_SCAN)   || (state_reg == ltc_pkg::S_TOUCH) ||
                        (state_reg == ltc_pkg::S_EVSCAN) || (state_reg == ltc_pkg::S_INCR);
    assign out_free   = !rsp_vld_reg || rsp.ready;
    assign accept     = req.valid && (state_reg == ltc_pkg::S_IDLE);

    // Clamp the limit: zero acts as one, anything above the store size as the size
    always_comb
    begin
        lim = LW'(max_tiles_reg);
        if (max_tiles_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (lim > LW'(ENTRIES))
        begin
            lim = LW'(ENTRIES);
        end
    end

    assign need_evict = (LW'(occ_reg) >= lim) && (evn_reg < ltc_pkg::EVICT_CAP);
    // After the eviction in flight, is yet another victim due?
    assign more_evict = (LW'(occ_m1) >= lim) && (evn_reg < ltc_pkg::EVICT_CAP_M1);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ltc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.func == ltc_pkg::FUNC_CLEAR) ? ltc_pkg::S_CLEAR
                                                                   : ltc_pkg::S_SCAN;
                end
            end
            ltc_pkg::S_SCAN:
            begin
                if (sweep_done)
                begin
                    state_next = ltc_pkg::S_DECIDE;
                end
            end
            ltc_pkg::S_DECIDE:
            begin
                if (hit_found_reg)
                begin
                    state_next = ltc_pkg::S_TOUCH;
                end
                else if (func_reg == ltc_pkg::FUNC_INSERT)
                begin
                    state_next = ltc_pkg::S_EVCHK;
                end
                else
                begin
                    state_next = ltc_pkg::S_EMIT;
                end
            end
            ltc_pkg::S_TOUCH:
            begin
                if (sweep_done)
                begin
                    state_next = ltc_pkg::S_EMIT;
                end
            end
            ltc_pkg::S_EVCHK:
            begin
                state_next = (need_evict && old_found_reg) ? ltc_pkg::S_EVICT
                                                           : ltc_pkg::S_PLACE;
            end
            ltc_pkg::S_EVICT:
            begin
                if (out_free)
                begin
                    state_next = more_evict ? ltc_pkg::S_EVSCAN : ltc_pkg::S_PLACE;
                end
            end
            ltc_pkg::S_EVSCAN:
            begin
                if (sweep_done)
                begin
                    state_next = ltc_pkg::S_EVCHK;
                end
            end
            ltc_pkg::S_PLACE:
            begin
                if (free_found_reg)
                begin
                    state_next = ltc_pkg::S_INCR;
                end
                else if (out_free)
                begin
                    state_next = ltc_pkg::S_IDLE;
                end
            end
            ltc_pkg::S_INCR:
            begin
                if (sweep_done)
                begin
                    state_next = ltc_pkg::S_INS;
                end
            end
            ltc_pkg::S_INS, ltc_pkg::S_EMIT, ltc_pkg::S_CLEAR:
            begin
                if (out_free)
                begin
                    state_next = ltc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ltc_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath control
    // ------------------------------------------------------------------
    logic                         emit;
    logic [ltc_pkg::STATUS_W-1:0] emit_status;
    logic [AW-1:0]                emit_idx;
    logic                         emit_idx_zero;
    logic [KW-1:0]                emit_key;
    logic                         emit_last;

    always_comb
    begin
        func_next       = func_reg;
        key_next        = key_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_key_next    = old_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        evn_next        = evn_reg;
        st_next         = st_reg;

        ram_we    = 1'b0;
        ram_waddr = rd_idx_reg;
        ram_wdata = {rd_rank, rd_key};
        ram_raddr = cnt_reg[AW-1:0];

        emit          = 1'b0;
        emit_status   = ltc_pkg::ST_MISS;
        emit_idx      = hit_idx_reg;
        emit_idx_zero = 1'b0;
        emit_key      = '0;
        emit_last     = 1'b1;

        // Every sweep reads one entry a cycle; its data come back in the following cycle
        if (in_sweep && issue)
        begin
            cnt_next    = cnt_reg + CW'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = cnt_reg[AW-1:0];
        end

        case (state_reg)
            ltc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next       = req.func;
                    key_next        = {req.channel, req.level, req.tile_index};
                    cnt_next        = '0;
                    hit_found_next  = 1'b0;
                    old_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    evn_next        = '0;
                end
            end
            ltc_pkg::S_SCAN:
            begin
                // Find the key, the least recent entry and the lowest free slot
                if (rd_vld_reg)
                begin
                    if (rd_valid && (rd_key == key_reg) && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_rank_next  = rd_rank;
                    end
                    if (rd_oldest)
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = rd_idx_reg;
                        old_key_next   = rd_key;
                    end
                    if (!rd_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
            end
            ltc_pkg::S_DECIDE:
            begin
                cnt_next = '0;
                if (func_reg == ltc_pkg::FUNC_INSERT)
                begin
                    st_next = ltc_pkg::ST_PRESENT;
                end
                else
                begin
                    st_next = hit_found_reg ? ltc_pkg::ST_HIT : ltc_pkg::ST_MISS;
                end
            end
            ltc_pkg::S_TOUCH:
            begin
                // Age everything younger than the hit entry, make the hit youngest
                if (rd_vld_reg && rd_valid)
                begin
                    if (rd_idx_reg == hit_idx_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {{RW{1'b0}}, rd_key};
                    end
                    else if (rd_rank < hit_rank_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_rank_inc, rd_key};
                    end
                end
            end
            ltc_pkg::S_EVICT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = ltc_pkg::ST_EVICTED;
                    emit_idx    = old_idx_reg;
                    emit_key    = old_key_reg;
                    emit_last   = 1'b0;
                    valid_next[old_idx_reg] = 1'b0;
                    occ_next       = occ_m1;
                    evn_next       = evn_reg + EW'(1);
                    old_found_next = 1'b0;
                    cnt_next       = '0;
                    // The freed slot may now be the lowest free one
                    if (!free_found_reg || (old_idx_reg < free_idx_reg))
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = old_idx_reg;
                    end
                end
            end
            ltc_pkg::S_EVSCAN:
            begin
                if (rd_vld_reg && rd_oldest)
                begin
                    old_found_next = 1'b1;
                    old_idx_next   = rd_idx_reg;
                    old_key_next   = rd_key;
                end
            end
            ltc_pkg::S_PLACE:
            begin
                cnt_next = '0;
                if (!free_found_reg && out_free)
                begin
                    // No slot to take: report a miss and drop the insert
                    emit          = 1'b1;
                    emit_status   = ltc_pkg::ST_MISS;
                    emit_idx_zero = 1'b1;
                end
            end
            ltc_pkg::S_INCR:
            begin
                // Every kept entry gets one older
                if (rd_vld_reg && rd_valid)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {rd_rank_inc, rd_key};
                end
            end
            ltc_pkg::S_INS:
            begin
                if (out_free)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                    ram_wdata = {{RW{1'b0}}, key_reg};
                    valid_next[free_idx_reg] = 1'b1;
                    occ_next    = occ_reg + OW'(1);
                    emit        = 1'b1;
                    emit_status = ltc_pkg::ST_INSERTED;
                    emit_idx    = free_idx_reg;
                end
            end
            ltc_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    emit_status   = st_reg;
                    emit_idx_zero = (st_reg == ltc_pkg::ST_MISS);
                end
            end
            ltc_pkg::S_CLEAR:
            begin
                if (out_free)
                begin
                    valid_next    = '0;
                    occ_next      = '0;
                    emit          = 1'b1;
                    emit_status   = ltc_pkg::ST_CLEARED;
                    emit_idx_zero = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Slot carries the low bits of the entry index
    logic [SW+AW-1:0] emit_idx_ext;
    assign emit_idx_ext = {{SW{1'b0}}, (emit_idx_zero ? {AW{1'b0}} : emit_idx)};

    // Hold a result until taken; load a new one whenever the register frees
    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (emit)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        max_tiles_next = max_tiles_reg;
        if (cfg.valid)
        begin
            max_tiles_next = cfg.max_tiles;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ltc_pkg::S_IDLE;
            max_tiles_reg  <= ltc_pkg::MAXT_RST;
            valid_reg      <= '0;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            evn_reg        <= '0;
            rsp_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_tiles_reg  <= max_tiles_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            hit_found_reg  <= hit_found_next;
            old_found_reg  <= old_found_next;
            free_found_reg <= free_found_next;
            evn_reg        <= evn_next;
            rsp_vld_reg    <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        rd_idx_reg   <= rd_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        old_idx_reg  <= old_idx_next;
        old_key_reg  <= old_key_next;
        free_idx_reg <= free_idx_next;
        st_reg       <= st_next;
        if (emit)
        begin
            rsp_status_reg <= emit_status;
            rsp_slot_reg   <= emit_idx_ext[SW-1:0];
            rsp_key_reg    <= emit_key;
            rsp_last_reg   <= emit_last;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign req.ready         = (state_reg == ltc_pkg::S_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_vld_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.slot          = rsp_slot_reg;
    assign rsp.evict_channel = rsp_key_reg[KW-1:TW+LVW];
    assign rsp.evict_level   = rsp_key_reg[TW+LVW-1:TW];
    assign rsp.evict_tile    = rsp_key_reg[TW-1:0];
    assign rsp.last          = rsp_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLKD(a_occ_matches_valid, clk, rst_n, $countones(valid_reg) == occ_reg)
    `ASSERT_NEVER(a_occ_in_range, clk, rst_n, occ_reg > OW'(ENTRIES))
    `ASSERT_CLKD(a_evict_not_last, clk, rst_n, (rsp_vld_reg && (rsp_status_reg == ltc_pkg::ST_EVICTED)) |-> !rsp_last_reg)
    `ASSERT_CLKD(a_clear_empties, clk, rst_n, ((state_reg == ltc_pkg::S_CLEAR) && out_free) |=> (valid_reg == '0))
    `ASSERT_CLKD(a_evict_capped, clk, rst_n, (state_reg == ltc_pkg::S_EVICT) |-> (evn_reg < ltc_pkg::EVICT_CAP))

endmodule

// File: rtl/ltc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: dv/tb_lru_tile_tag_cache.sv
// Self-checking testbench for lru_tile_tag_cache: drives request and limit words,
// predicts every result word of the LRU tag store and checks them in order.
// Depends on ltc_pkg, the ltc interfaces and the RTL of the tag cache.
`timescale 1ns / 1ps

module tb_lru_tile_tag_cache;

    localparam int ENTRIES = 64;

    // Lookup has no name in the package; the unused code also acts as a lookup
    localparam logic [ltc_pkg::FUNC_W-1:0] FUNC_LOOKUP     = 2'd0;
    localparam logic [ltc_pkg::FUNC_W-1:0] FUNC_LOOKUP_ALT = 2'd3;

    // Report the first few mismatches in full, count the rest
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ltc_pkg::CHAN_W-1:0]  channel;
        logic [ltc_pkg::LEVEL_W-1:0] level;
        logic [ltc_pkg::TILE_W-1:0]  tile;
    } tile_key_t;

    typedef struct packed {
        logic [ltc_pkg::STATUS_W-1:0] status;
        logic [ltc_pkg::SLOT_W-1:0]   slot;
        tile_key_t                    victim;
        logic                         last;
    } tag_result_t;

    // Scoreboard: own copy of the tag store, its ages and the limit; predicts
    // the result words of each accepted request and checks them in order.
    class tag_cache_scoreboard;
        bit                   line_valid [ENTRIES];
        tile_key_t            line_key   [ENTRIES];
        int unsigned          line_age   [ENTRIES];
        int unsigned          fill;
        int unsigned          limit_reg;
        tag_result_t          expected_words [$];
        int unsigned          mismatches;

        function new();
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
                line_key[i]   = '0;
                line_age[i]   = 0;
            end
            fill       = 0;
            limit_reg  = ltc_pkg::MAXT_RST;
            mismatches = 0;
        endfunction

        function void set_limit(logic [ltc_pkg::MAXT_W-1:0] value);
            limit_reg = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_word(logic [ltc_pkg::STATUS_W-1:0] st, int slot_idx,
                                tile_key_t victim, logic last);
            tag_result_t w;
            w.status = st;
            w.slot   = slot_idx[ltc_pkg::SLOT_W-1:0];
            w.victim = victim;
            w.last   = last;
            expected_words.insert(expected_words.size(), w);
        endfunction

        // Make a valid line the most recent; younger lines age by one
        function void promote(int idx);
            int unsigned a;
            a = line_age[idx];
            foreach (line_valid[i])
                if (line_valid[i] && line_age[i] < a)
                    line_age[i]++;
            line_age[idx] = 0;
        endfunction

        function void note_request(logic [ltc_pkg::FUNC_W-1:0] fn, tile_key_t k);
            int          hit_idx;
            int          victim;
            int          free_idx;
            int unsigned lim;
            int unsigned evicted;
            hit_idx  = -1;
            victim   = -1;
            free_idx = -1;
            evicted  = 0;

            if (fn == ltc_pkg::FUNC_CLEAR)
            begin
                foreach (line_valid[i])
                    line_valid[i] = 1'b0;
                fill = 0;
                push_word(ltc_pkg::ST_CLEARED, 0, '0, 1'b1);
                return;
            end

            foreach (line_valid[i])
                if (hit_idx < 0 && line_valid[i] && line_key[i] == k)
                    hit_idx = i;

            if (fn != ltc_pkg::FUNC_INSERT)
            begin
                if (hit_idx < 0)
                    push_word(ltc_pkg::ST_MISS, 0, '0, 1'b1);
                else
                begin
                    promote(hit_idx);
                    push_word(ltc_pkg::ST_HIT, hit_idx, '0, 1'b1);
                end
                return;
            end

            if (hit_idx >= 0)
            begin
                promote(hit_idx);
                push_word(ltc_pkg::ST_PRESENT, hit_idx, '0, 1'b1);
                return;
            end

            // Clamp the limit to 1 .. ENTRIES, then evict the oldest lines
            lim = limit_reg;
            if (lim < 1)
                lim = 1;
            if (lim > ENTRIES)
                lim = ENTRIES;

            while (fill >= lim && evicted < ltc_pkg::EVICT_CAP)
            begin
                victim = -1;
                foreach (line_valid[i])
                    if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
                        victim = i;
                if (victim < 0)
                    break;
                line_valid[victim] = 1'b0;
                fill--;
                push_word(ltc_pkg::ST_EVICTED, victim, line_key[victim], 1'b0);
                evicted++;
            end

            foreach (line_valid[i])
                if (free_idx < 0 && !line_valid[i])
                    free_idx = i;
            foreach (line_valid[i])
                if (line_valid[i])
                    line_age[i]++;
            line_valid[free_idx] = 1'b1;
            line_key[free_idx]   = k;
            line_age[free_idx]   = 0;
            fill++;
            push_word(ltc_pkg::ST_INSERTED, free_idx, '0, 1'b1);
        endfunction

        function void report(string what, tag_result_t want, tag_result_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s: expected st=%0d slot=%0d ch=%0d lvl=%0d tile=%h last=%0d,",
                         what, want.status, want.slot, want.victim.channel,
                         want.victim.level, want.victim.tile, want.last,
                         " got st=%0d slot=%0d ch=%0d lvl=%0d tile=%h last=%0d",
                         got.status, got.slot, got.victim.channel,
                         got.victim.level, got.victim.tile, got.last);
        endfunction

        function void check_result(tag_result_t got);
            tag_result_t want;
            if (expected_words.size() == 0)
            begin
                report("unexpected result word", '0, got);
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.victim.channel !== want.victim.channel ||
                got.victim.level !== want.victim.level ||
                got.victim.tile !== want.victim.tile || got.last !== want.last)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ltc_req_if req_ch ();
    ltc_rsp_if rsp_ch ();
    ltc_cfg_if cfg_ch ();

    lru_tile_tag_cache #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    tag_cache_scoreboard sb;

    // Idling odds in percent, changed per phase
    int send_idle_pct;
    int recv_stall_pct;

    // 4 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: check each word accepted at this edge, then pick the next
    // ready level. Sampling before the edge's updates keeps this race-free.
    always @(posedge clk)
    begin
        tag_result_t got;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.status         = rsp_ch.status;
            got.slot           = rsp_ch.slot;
            got.victim.channel = rsp_ch.evict_channel;
            got.victim.level   = rsp_ch.evict_level;
            got.victim.tile    = rsp_ch.evict_tile;
            got.last           = rsp_ch.last;
            sb.check_result(got);
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Draw a key; now and then force a field to an extreme so every bit toggles
    function automatic tile_key_t fresh_key();
        tile_key_t   k;
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        k   = raw[ltc_pkg::KEY_W-1:0];
        case ($urandom_range(0, 11))
            0: k.tile    = '0;
            1: k.tile    = '1;
            2: k.channel = '1;
            3: k.channel = '0;
            4: k.level   = '1;
            5: k.level   = '0;
            default: ;
        endcase
        return k;
    endfunction

    // Present one request word; hold valid across back-to-back words
    task automatic send_request(input logic [ltc_pkg::FUNC_W-1:0] fn, input tile_key_t k);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= fn;
        req_ch.channel    <= k.channel;
        req_ch.level      <= k.level;
        req_ch.tile_index <= k.tile;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(fn, k);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the limit register; only called with the block idle
    task automatic write_limit(input logic [ltc_pkg::MAXT_W-1:0] value);
        drain_results();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.max_tiles <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Mostly inserts and lookups over a small working set with random content,
    // plus stray lookups, the unused code and the odd clear as noise.
    task automatic run_random(input int count, input int pool_size, input bit hold_mid);
        tile_key_t working_set [$];
        tile_key_t k;
        int        pick;
        for (int i = 0; i < pool_size; i++)
            working_set.insert(i, fresh_key());
        for (int i = 0; i < count; i++)
        begin
            if (hold_mid && i == count / 2)
                drain_results();
            k    = working_set[$urandom_range(0, pool_size - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_request(ltc_pkg::FUNC_INSERT, k);
            else if (pick < 77)
                send_request(FUNC_LOOKUP, k);
            else if (pick < 85)
                send_request(FUNC_LOOKUP_ALT, k);
            else if (pick < 97)
                send_request(($urandom_range(0, 1) != 0) ? FUNC_LOOKUP : FUNC_LOOKUP_ALT,
                             fresh_key());
            else
                send_request(ltc_pkg::FUNC_CLEAR, fresh_key());
        end
    endtask

    // Fill every line, overflow by one, then drop the limit so one insert
    // evicts the capped number of lines in a single request.
    task automatic run_fill_and_collapse();
        tile_key_t k;
        logic [ltc_pkg::TILE_W-1:0] base;
        base = $urandom();
        write_limit(7'd127);
        send_request(ltc_pkg::FUNC_CLEAR, '0);
        for (int i = 0; i <= ENTRIES; i++)
        begin
            k      = fresh_key();
            k.tile = base + i;
            send_request(ltc_pkg::FUNC_INSERT, k);
        end
        write_limit(7'd2);
        k      = fresh_key();
        k.tile = base - 1;
        send_request(ltc_pkg::FUNC_INSERT, k);
    endtask

    // Directed words: extreme keys, every code, hit, miss, present, clear
    task automatic run_directed();
        tile_key_t k_zero;
        tile_key_t k_ones;
        tile_key_t k_near;
        k_zero = '0;
        k_ones = '1;
        k_near = '1;
        k_near.tile[0] = 1'b0;
        send_request(ltc_pkg::FUNC_CLEAR, k_ones);      // clear an empty store
        send_request(FUNC_LOOKUP, k_zero);              // miss on empty
        send_request(ltc_pkg::FUNC_INSERT, k_zero);     // lowest free line
        send_request(ltc_pkg::FUNC_INSERT, k_ones);
        send_request(ltc_pkg::FUNC_INSERT, k_zero);     // already present
        send_request(FUNC_LOOKUP, k_ones);              // hit
        send_request(FUNC_LOOKUP_ALT, k_zero);          // unused code hits too
        send_request(FUNC_LOOKUP, k_near);              // one bit off: miss
        send_request(FUNC_LOOKUP_ALT, k_near);
        send_request(ltc_pkg::FUNC_INSERT, '{10'd512, 6'd32, 32'h8000_0000});
        send_request(ltc_pkg::FUNC_INSERT, '{10'd1, 6'd1, 32'h1});
        send_request(FUNC_LOOKUP, '{10'd512, 6'd32, 32'h8000_0000});
        send_request(ltc_pkg::FUNC_INSERT, k_near);
        send_request(FUNC_LOOKUP, k_zero);
        send_request(ltc_pkg::FUNC_CLEAR, k_zero);
        send_request(FUNC_LOOKUP, k_ones);              // gone after clear
        send_request(ltc_pkg::FUNC_INSERT, '{10'd1023, 6'd0, 32'h0});
        send_request(ltc_pkg::FUNC_INSERT, k_ones);
        send_request(FUNC_LOOKUP, '{10'd1023, 6'd0, 32'h0});
        send_request(ltc_pkg::FUNC_CLEAR, k_ones);
    endtask

    // Main sequence
    initial
    begin
        sb = new();
        set_idling(0, 0);
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_LOOKUP;
        req_ch.channel    = '0;
        req_ch.level      = '0;
        req_ch.tile_index = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.max_tiles  = '0;
        rsp_ch.ready      = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_limit(ltc_pkg::MAXT_RST);
        run_directed();
        run_fill_and_collapse();

        // Limit 0 acts as 1
        write_limit(7'd0);
        set_idling(64, 0);
        run_random(40, 3, 1'b0);

        write_limit(7'd4);
        set_idling(0, 64);
        run_random(90, 7, 1'b0);

        write_limit(7'd16);
        set_idling(36, 36);
        run_random(90, 22, 1'b1);

        write_limit(7'd64);
        set_idling(0, 0);
        run_random(45, 72, 1'b0);

        // Limit above the line count acts as the full store
        write_limit(7'd100);
        set_idling(64, 64);
        run_random(60, 70, 1'b0);

        drain_results();
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_lru_tile_tag_cache OK");
        else
            $display("tb_lru_tile_tag_cache NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #40000000;
        $display("tb_lru_tile_tag_cache NOT OK");
        $finish;
    end

endmodule
